// File: rtl/led_bar_register_controller_macros.svh
// Assertion macros for the LED bar register controller.
// Used by the top level only; no other dependencies.
`ifndef LED_BAR_REGISTER_CONTROLLER_MACROS_SVH
`define LED_BAR_REGISTER_CONTROLLER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LBRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbrc: implication check failed");

// Next-cycle implication, masked during reset.
`define LBRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbrc: next-cycle check failed");

`endif

// File: rtl/lbrc_pkg.sv
// Shared types and constants for the LED bar register controller.
// No dependencies; used by every RTL module of the block.
package lbrc_pkg;

    // Input word codes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Values of the mode register
    localparam logic [7:0] RF_MODE_FILL   = 8'd0;
    localparam logic [7:0] RF_MODE_SINGLE = 8'd1;

    localparam int         REG_DEPTH      = 5;
    localparam logic [2:0] REG_LAST       = 3'(REG_DEPTH - 1);
    localparam logic [7:0] LEVEL_STEP     = 8'd10;
    localparam logic [3:0] MAX_RESULTS    = 4'd12;
    localparam logic [7:0] INTERVAL_RESET = 8'd120;

    localparam int         PULSE_LEN  = 14;
    localparam logic [3:0] PULSE_LAST = 4'(PULSE_LEN - 1);
    localparam logic [7:0] PULSE_TABLE [PULSE_LEN] = '{
        8'h02, 8'h03, 8'h04, 8'h05, 8'h07, 8'h0a, 8'h0f,
        8'h0a, 8'h07, 8'h05, 8'h04, 8'h03, 8'h01, 8'h01
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_count;
        logic [39:0] payload_bytes;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] read_data;
        logic       last;
    } out_word_t;

    // Contents of the register file as seen by the redraw logic
    typedef struct packed {
        logic [7:0] mode;
        logic [7:0] count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rf_view_t;

    // Sequencer requests to the output queue
    typedef struct packed {
        logic push;
        logic finish;
    } oq_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ATTEMPT,
        S_ACCEPT,
        S_STORE,
        S_REDRAW,
        S_FILL,
        S_CLEAR,
        S_SINGLE,
        S_TICK,
        S_READ,
        S_DONE
    } seq_state_t;

endpackage

// File: rtl/led_bar_register_controller.sv
// LED bar register controller. Takes one input word at a time: a bus write
// transaction, a millisecond tick or a read request, and answers with pixel
// colour writes or a read reply, the final word of each item flagged by last.
// A sequencer walks each item with one shared index counter, one step a cycle
// unless the output queue holds it. An item gives at most twelve results.
// While an item is in progress in_stall stays high. The output register and one
// pending word sit between the sequencer and the output, so output stalls only
// hold the sequencer once both are full. pulse_interval is written through
// cfg_wen/cfg_wdata and should only change while the block is idle.
`include "led_bar_register_controller_macros.svh"

module led_bar_register_controller #(
    parameter int PIXEL_COUNT  = 10,
    parameter int MAX_TRANSFER = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lbrc_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output lbrc_pkg::out_word_t out_word,
    input  logic                cfg_wen,
    input  logic [7:0]          cfg_wdata
);

    localparam logic [7:0] PC_B = 8'(PIXEL_COUNT);

    lbrc_pkg::oq_ctl_t   oq_ctl;
    lbrc_pkg::out_word_t cand;
    lbrc_pkg::rf_view_t  rf;
    logic                oq_ready;
    logic                rf_wen;
    logic [7:0]          rf_wdata;

    lbrc_seq #(
        .PIXEL_COUNT  (PIXEL_COUNT),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .oq_ready  (oq_ready),
        .oq_ctl    (oq_ctl),
        .cand      (cand),
        .rf_wen    (rf_wen),
        .rf_wdata  (rf_wdata),
        .rf        (rf)
    );

    lbrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rf_wen),
        .wr_data (rf_wdata),
        .rf      (rf)
    );

    lbrc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (oq_ctl),
        .cand      (cand),
        .ready     (oq_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // An accepted word keeps the sequencer busy for at least the following cycle
    `LBRC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A read reply is always the only and final word of its item
    `LBRC_ASSERT_IMPLY(a_read_reply_last, clk, rst_n,
        out_valid && (out_word.result_kind == lbrc_pkg::KIND_READ),
        out_word.last && (out_word.read_data == PC_B))

endmodule

// File: rtl/lbrc_regs.sv
// Five-entry register file (mode, count, red, green, blue) with a wrapping write pointer.
// Depends on lbrc_pkg.
module lbrc_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [7:0]        wr_data,
    output lbrc_pkg::rf_view_t rf
);

    logic [7:0] file_reg [lbrc_pkg::REG_DEPTH];
    logic [2:0] ptr_reg;
    logic [2:0] ptr_next;
    logic [2:0] ptr_eff;

    always_comb
    begin
        ptr_eff  = (ptr_reg > lbrc_pkg::REG_LAST) ? 3'd0 : ptr_reg;
        ptr_next = ptr_reg;
        if (wr_en)
        begin
            ptr_next = (ptr_eff == lbrc_pkg::REG_LAST) ? 3'd0 : ptr_eff + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= 3'd0;
            for (int k = 0; k < lbrc_pkg::REG_DEPTH; k++)
            begin
                file_reg[k] <= 8'd0;
            end
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (wr_en)
            begin
                file_reg[ptr_eff] <= wr_data;
            end
        end
    end

    assign rf.mode  = file_reg[0];
    assign rf.count = file_reg[1];
    assign rf.red   = file_reg[2];
    assign rf.green = file_reg[3];
    assign rf.blue  = file_reg[4];

endmodule

// File: rtl/lbrc_outq.sv
// Output queue: one pending word plus the output register; marks the final word of an item.
// Depends on lbrc_pkg.
module lbrc_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  lbrc_pkg::oq_ctl_t   ctl,
    input  lbrc_pkg::out_word_t cand,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output lbrc_pkg::out_word_t out_word
);

    logic                pend_valid_reg;
    logic                pend_valid_next;
    lbrc_pkg::out_word_t pend_reg;
    lbrc_pkg::out_word_t pend_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    lbrc_pkg::out_word_t out_word_reg;
    lbrc_pkg::out_word_t out_word_next;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign ready    = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;
        if (ready && ctl.push)
        begin
            // a newer word exists, so the pending one is not the last
            if (pend_valid_reg)
            begin
                out_word_next      = pend_reg;
                out_word_next.last = 1'b0;
                out_valid_next     = 1'b1;
            end
            pend_next       = cand;
            pend_valid_next = 1'b1;
        end
        else if (ready && ctl.finish && pend_valid_reg)
        begin
            out_word_next      = pend_reg;
            out_word_next.last = 1'b1;
            out_valid_next     = 1'b1;
            pend_valid_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// File: rtl/lbrc_seq.sv
// Sequencer: walks one input word through its steps with a shared index counter.
// Holds the activity levels, pulse timer and interval register. Depends on lbrc_pkg.
module lbrc_seq #(
    parameter int PIXEL_COUNT  = 10,
    parameter int MAX_TRANSFER = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lbrc_pkg::in_word_t  in_word,
    input  logic                cfg_wen,
    input  logic [7:0]          cfg_wdata,
    input  logic                oq_ready,
    output lbrc_pkg::oq_ctl_t   oq_ctl,
    output lbrc_pkg::out_word_t cand,
    output logic                rf_wen,
    output logic [7:0]          rf_wdata,
    input  lbrc_pkg::rf_view_t  rf
);

    localparam logic [7:0] PC_B    = 8'(PIXEL_COUNT);
    localparam logic [7:0] PC_M1   = 8'(PIXEL_COUNT - 1);
    localparam logic [7:0] PC_M2   = 8'(PIXEL_COUNT - 2);
    localparam logic [7:0] PC_M3   = 8'(PIXEL_COUNT - 3);
    localparam logic [7:0] MAX_T_B = 8'(MAX_TRANSFER);

    lbrc_pkg::seq_state_t state_reg;
    lbrc_pkg::seq_state_t state_next;
    lbrc_pkg::in_word_t   item_reg;
    lbrc_pkg::in_word_t   item_next;
    logic [7:0]           idx_reg;
    logic [7:0]           idx_next;
    logic [3:0]           n_reg;
    logic [3:0]           n_next;
    logic [7:0]           attempt_reg;
    logic [7:0]           attempt_next;
    logic [7:0]           accepted_reg;
    logic [7:0]           accepted_next;
    logic [3:0]           step_reg;
    logic [3:0]           step_next;
    logic [7:0]           elapsed_reg;
    logic [7:0]           elapsed_next;
    logic [7:0]           interval_reg;

    logic       accept;
    logic       count_ok;
    logic       store_last;
    logic       fill_hit;
    logic       clear_hit;
    logic       single_hit;
    logic       cap;
    logic [8:0] elapsed_inc;
    logic       tick_step;
    logic [3:0] step_eff;
    logic [7:0] idx_inc;

    function automatic lbrc_pkg::out_word_t pixel(input logic [7:0] idx,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        lbrc_pkg::out_word_t w;
        w             = '0;
        w.result_kind = lbrc_pkg::KIND_PIXEL;
        w.pixel_index = idx[3:0];
        w.red         = r;
        w.green       = g;
        w.blue        = b;
        return w;
    endfunction

    assign in_stall    = (state_reg != lbrc_pkg::S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign idx_inc     = idx_reg + 8'd1;
    assign count_ok    = (item_reg.byte_count != 8'd0) && (item_reg.byte_count <= MAX_T_B);
    assign store_last  = (idx_inc == item_reg.byte_count);
    assign fill_hit    = (idx_reg < rf.count) && (idx_reg < PC_B);
    assign clear_hit   = (idx_reg < PC_M3);
    assign single_hit  = (rf.count != 8'd0) && (rf.count <= PC_B);
    assign cap         = (n_reg == lbrc_pkg::MAX_RESULTS);
    assign elapsed_inc = {1'b0, elapsed_reg} + 9'd1;
    assign tick_step   = (elapsed_inc > {1'b0, interval_reg});
    assign step_eff    = (step_reg > lbrc_pkg::PULSE_LAST) ? 4'd0 : step_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbrc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_word.mode)
                        lbrc_pkg::MODE_WRITE: state_next = lbrc_pkg::S_ATTEMPT;
                        lbrc_pkg::MODE_TICK:  state_next = lbrc_pkg::S_TICK;
                        lbrc_pkg::MODE_READ:  state_next = lbrc_pkg::S_READ;
                        default:              state_next = lbrc_pkg::S_DONE;
                    endcase
                end
            end
            lbrc_pkg::S_ATTEMPT:
            begin
                if (oq_ready)
                begin
                    state_next = count_ok ? lbrc_pkg::S_ACCEPT : lbrc_pkg::S_DONE;
                end
            end
            lbrc_pkg::S_ACCEPT:
            begin
                if (oq_ready)
                begin
                    state_next = lbrc_pkg::S_STORE;
                end
            end
            lbrc_pkg::S_STORE:
            begin
                if (oq_ready && store_last)
                begin
                    state_next = lbrc_pkg::S_REDRAW;
                end
            end
            lbrc_pkg::S_REDRAW:
            begin
                if (oq_ready)
                begin
                    case (rf.mode)
                        lbrc_pkg::RF_MODE_FILL:   state_next = lbrc_pkg::S_FILL;
                        lbrc_pkg::RF_MODE_SINGLE: state_next = lbrc_pkg::S_SINGLE;
                        default:                  state_next = lbrc_pkg::S_DONE;
                    endcase
                end
            end
            lbrc_pkg::S_FILL:
            begin
                if (oq_ready)
                begin
                    if (cap)
                    begin
                        state_next = lbrc_pkg::S_DONE;
                    end
                    else if (!fill_hit)
                    begin
                        state_next = lbrc_pkg::S_CLEAR;
                    end
                end
            end
            lbrc_pkg::S_CLEAR:
            begin
                if (oq_ready && (cap || !clear_hit))
                begin
                    state_next = lbrc_pkg::S_DONE;
                end
            end
            lbrc_pkg::S_SINGLE,
            lbrc_pkg::S_TICK,
            lbrc_pkg::S_READ:
            begin
                if (oq_ready)
                begin
                    state_next = lbrc_pkg::S_DONE;
                end
            end
            lbrc_pkg::S_DONE:
            begin
                if (oq_ready)
                begin
                    state_next = lbrc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lbrc_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and requests
    always_comb
    begin
        oq_ctl        = '0;
        cand          = '0;
        rf_wen        = 1'b0;
        rf_wdata      = item_reg.payload_bytes[7:0];
        item_next     = item_reg;
        idx_next      = idx_reg;
        attempt_next  = attempt_reg;
        accepted_next = accepted_reg;
        step_next     = step_reg;
        elapsed_next  = elapsed_reg;
        case (state_reg)
            lbrc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_word;
                    idx_next  = 8'd0;
                end
            end
            lbrc_pkg::S_ATTEMPT:
            begin
                if (oq_ready)
                begin
                    oq_ctl.push  = 1'b1;
                    cand         = pixel(PC_M2, attempt_reg, 8'd0, 8'd0);
                    attempt_next = attempt_reg + lbrc_pkg::LEVEL_STEP;
                end
            end
            lbrc_pkg::S_ACCEPT:
            begin
                if (oq_ready)
                begin
                    oq_ctl.push   = 1'b1;
                    cand          = pixel(PC_M3, accepted_reg, 8'd0, 8'd0);
                    accepted_next = accepted_reg + lbrc_pkg::LEVEL_STEP;
                    idx_next      = 8'd0;
                end
            end
            lbrc_pkg::S_STORE:
            begin
                // one byte a cycle while the output queue is ready, first byte from the low end
                rf_wdata = 8'(item_reg.payload_bytes >> {idx_reg[2:0], 3'b000});
                if (oq_ready)
                begin
                    rf_wen   = 1'b1;
                    idx_next = store_last ? 8'd0 : idx_inc;
                end
            end
            lbrc_pkg::S_FILL:
            begin
                if (oq_ready && !cap)
                begin
                    if (fill_hit)
                    begin
                        oq_ctl.push = 1'b1;
                        cand        = pixel(idx_reg, rf.red, rf.green, rf.blue);
                        idx_next    = idx_inc;
                    end
                    else
                    begin
                        // clearing starts at the count, not where filling stopped
                        idx_next = rf.count;
                    end
                end
            end
            lbrc_pkg::S_CLEAR:
            begin
                if (oq_ready && !cap && clear_hit)
                begin
                    oq_ctl.push = 1'b1;
                    cand        = pixel(idx_reg, 8'd0, 8'd0, 8'd0);
                    idx_next    = idx_inc;
                end
            end
            lbrc_pkg::S_SINGLE:
            begin
                if (oq_ready && single_hit)
                begin
                    oq_ctl.push = 1'b1;
                    cand        = pixel(rf.count - 8'd1, rf.red, rf.green, rf.blue);
                end
            end
            lbrc_pkg::S_TICK:
            begin
                if (oq_ready)
                begin
                    if (tick_step)
                    begin
                        oq_ctl.push  = 1'b1;
                        cand         = pixel(PC_M1, 8'd0, 8'd0,
                                             lbrc_pkg::PULSE_TABLE[step_eff]);
                        elapsed_next = 8'd0;
                        step_next    = (step_eff == lbrc_pkg::PULSE_LAST) ? 4'd0
                                                                          : step_eff + 4'd1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc[7:0];
                    end
                end
            end
            lbrc_pkg::S_READ:
            begin
                if (oq_ready)
                begin
                    oq_ctl.push      = 1'b1;
                    cand.result_kind = lbrc_pkg::KIND_READ;
                    cand.read_data   = PC_B;
                end
            end
            lbrc_pkg::S_DONE:
            begin
                oq_ctl.finish = oq_ready;
            end
            default:
            begin
                oq_ctl = '0;
            end
        endcase
        n_next = accept ? 4'd0 : (oq_ctl.push ? n_reg + 4'd1 : n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lbrc_pkg::S_IDLE;
            idx_reg      <= 8'd0;
            n_reg        <= 4'd0;
            attempt_reg  <= lbrc_pkg::LEVEL_STEP;
            accepted_reg <= lbrc_pkg::LEVEL_STEP;
            step_reg     <= 4'd0;
            elapsed_reg  <= 8'd0;
            interval_reg <= lbrc_pkg::INTERVAL_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            n_reg        <= n_next;
            attempt_reg  <= attempt_next;
            accepted_reg <= accepted_next;
            step_reg     <= step_next;
            elapsed_reg  <= elapsed_next;
            if (cfg_wen)
            begin
                interval_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// File: sim/led_bar_register_controller_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the LED bar register controller: feeds write, tick and read words,
// predicts every pixel and read reply and checks each output word in order.
// Depends on lbrc_pkg and led_bar_register_controller.
module led_bar_register_controller_test;

    localparam int         BAR_PIXELS     = 10;
    localparam int         BAR_MAX_BYTES  = 5;
    localparam int         ITEM_WORDS_MAX = 12;
    localparam int         REG_SLOTS      = 5;
    localparam int         PULSE_STEPS    = 14;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         QUIET_LIMIT    = 1000;
    localparam int         HOLD_START     = 40;
    localparam int         HOLD_CYCLES    = 200;

    localparam logic [7:0] PULSE_LEVELS [PULSE_STEPS] = '{
        8'h02, 8'h03, 8'h04, 8'h05, 8'h07, 8'h0a, 8'h0f,
        8'h0a, 8'h07, 8'h05, 8'h04, 8'h03, 8'h01, 8'h01
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    lbrc_pkg::in_word_t  in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    lbrc_pkg::out_word_t out_word;
    logic                cfg_wen   = 1'b0;
    logic [7:0]          cfg_wdata = '0;

    // stimulus and expectations
    lbrc_pkg::in_word_t  feed_words[$];
    lbrc_pkg::out_word_t due_words[$];
    lbrc_pkg::out_word_t item_words[$];
    int         tx_idle_pct    = 0;
    int         rx_idle_pct    = 0;
    int         accepted_items = 0;
    int         fault_count    = 0;
    int         quiet_cycles   = 0;
    int         hold_left      = 0;
    logic       hold_done      = 1'b0;
    logic [2:0] gen_ptr        = '0;

    // shadow of the block's state
    logic [7:0] bar_regs [REG_SLOTS];
    logic [2:0] reg_ptr      = '0;
    logic [7:0] try_level    = 8'd10;
    logic [7:0] ok_level     = 8'd10;
    logic [3:0] pulse_idx    = '0;
    logic [7:0] ms_count     = '0;
    logic [7:0] interval_reg = 8'd120;

    led_bar_register_controller #(
        .PIXEL_COUNT  (BAR_PIXELS),
        .MAX_TRANSFER (BAR_MAX_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void add_bar_word(logic kind, int idx, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b, logic [7:0] d);
        lbrc_pkg::out_word_t o;
        if (item_words.size() >= ITEM_WORDS_MAX)
            return;
        o.result_kind = kind;
        o.pixel_index = 4'(idx);
        o.red         = r;
        o.green       = g;
        o.blue        = b;
        o.read_data   = d;
        o.last        = 1'b0;
        item_words.push_back(o);
    endfunction

    // Work out the pixel writes and read reply that one accepted word causes.
    function automatic void compute_bar_writes(lbrc_pkg::in_word_t w);
        int                  i;
        int                  cnt;
        logic [8:0]          ms_next;
        lbrc_pkg::out_word_t o;
        item_words.delete();
        case (w.mode)
            lbrc_pkg::MODE_WRITE:
            begin
                add_bar_word(lbrc_pkg::KIND_PIXEL, BAR_PIXELS - 2, try_level, 8'd0, 8'd0, 8'd0);
                try_level = try_level + 8'd10;
                if (w.byte_count >= 8'd1 && w.byte_count <= 8'(BAR_MAX_BYTES))
                begin
                    add_bar_word(lbrc_pkg::KIND_PIXEL, BAR_PIXELS - 3, ok_level, 8'd0, 8'd0,
                                 8'd0);
                    ok_level = ok_level + 8'd10;
                    for (i = 0; i < int'(w.byte_count); i++)
                    begin
                        bar_regs[reg_ptr] = w.payload_bytes[8*i +: 8];
                        reg_ptr = (reg_ptr == 3'(REG_SLOTS - 1)) ? 3'd0 : reg_ptr + 3'd1;
                    end
                    cnt = int'(bar_regs[1]);
                    if (bar_regs[0] == lbrc_pkg::RF_MODE_FILL)
                    begin
                        for (i = 0; i < cnt && i < BAR_PIXELS; i++)
                            add_bar_word(lbrc_pkg::KIND_PIXEL, i, bar_regs[2], bar_regs[3],
                                         bar_regs[4], 8'd0);
                        for (i = cnt; i < BAR_PIXELS - 3; i++)
                            add_bar_word(lbrc_pkg::KIND_PIXEL, i, 8'd0, 8'd0, 8'd0, 8'd0);
                    end
                    else if (bar_regs[0] == lbrc_pkg::RF_MODE_SINGLE)
                    begin
                        if (cnt >= 1 && cnt <= BAR_PIXELS)
                            add_bar_word(lbrc_pkg::KIND_PIXEL, cnt - 1, bar_regs[2], bar_regs[3],
                                         bar_regs[4], 8'd0);
                    end
                end
            end
            lbrc_pkg::MODE_TICK:
            begin
                // one extra bit so that an interval of 255 still steps
                ms_next = {1'b0, ms_count} + 9'd1;
                if (ms_next > {1'b0, interval_reg})
                begin
                    ms_count = '0;
                    add_bar_word(lbrc_pkg::KIND_PIXEL, BAR_PIXELS - 1, 8'd0, 8'd0,
                                 PULSE_LEVELS[pulse_idx], 8'd0);
                    pulse_idx = (pulse_idx == 4'(PULSE_STEPS - 1)) ? 4'd0 : pulse_idx + 4'd1;
                end
                else
                begin
                    ms_count = ms_next[7:0];
                end
            end
            lbrc_pkg::MODE_READ:
                add_bar_word(lbrc_pkg::KIND_READ, 0, 8'd0, 8'd0, 8'd0, 8'(BAR_PIXELS));
            default:
                ;
        endcase
        foreach (item_words[k])
        begin
            o = item_words[k];
            o.last = (k == item_words.size() - 1);
            due_words.push_back(o);
        end
    endfunction

    function automatic void queue_item(logic [1:0] m, logic [7:0] c, logic [39:0] p);
        lbrc_pkg::in_word_t w;
        w.mode          = m;
        w.byte_count    = c;
        w.payload_bytes = p;
        feed_words.push_back(w);
        if (m == lbrc_pkg::MODE_WRITE && c >= 8'd1 && c <= 8'(BAR_MAX_BYTES))
            gen_ptr = 3'((int'(gen_ptr) + int'(c)) % REG_SLOTS);
    endfunction

    // Mostly well-formed transactions whose bytes suit the register they land in.
    function automatic void queue_random_item();
        int          pick;
        int          i;
        int          slot;
        int          roll;
        logic [7:0]  cnt;
        logic [39:0] p;
        pick = $urandom_range(99);
        p    = {8'($urandom), 32'($urandom)};
        if (pick < 50)
        begin
            cnt = 8'($urandom_range(BAR_MAX_BYTES, 1));
            for (i = 0; i < int'(cnt); i++)
            begin
                slot = (int'(gen_ptr) + i) % REG_SLOTS;
                roll = $urandom_range(99);
                if (slot == 0)
                    p[8*i +: 8] = (roll < 45) ? lbrc_pkg::RF_MODE_FILL :
                                  (roll < 90) ? lbrc_pkg::RF_MODE_SINGLE : 8'($urandom);
                else if (slot == 1)
                    p[8*i +: 8] = (roll < 85) ? 8'($urandom_range(12)) : 8'($urandom);
            end
            queue_item(lbrc_pkg::MODE_WRITE, cnt, p);
        end
        else if (pick < 60)
            queue_item(lbrc_pkg::MODE_WRITE,
                       $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 6)), p);
        else if (pick < 80)
            queue_item(lbrc_pkg::MODE_TICK, 8'($urandom), p);
        else if (pick < 93)
            queue_item(lbrc_pkg::MODE_READ, 8'($urandom), p);
        else
            queue_item(MODE_UNUSED, 8'($urandom), p);
    endfunction

    // Wait until every word is sent and answered, then let a trailing silent item finish.
    task automatic settle();
        do
            @(negedge clk);
        while (feed_words.size() != 0 || in_valid || due_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_interval(input logic [7:0] v);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen      <= 1'b0;
        interval_reg = v;
    endtask

    // Input side: hold a stalled word, otherwise offer the next one or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                compute_bar_writes(in_word);
                accepted_items <= accepted_items + 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (feed_words.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_word  <= feed_words.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls, plus one long hold so the block backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && accepted_items >= HOLD_START)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        lbrc_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_words.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected word: kind %0d pixel %0d rgb %h %h %h data %h last %0d",
                             out_word.result_kind, out_word.pixel_index, out_word.red,
                             out_word.green, out_word.blue, out_word.read_data, out_word.last);
                fault_count++;
            end
            else
            begin
                want = due_words.pop_front();
                if (out_word.result_kind !== want.result_kind ||
                    out_word.pixel_index !== want.pixel_index ||
                    out_word.red !== want.red || out_word.green !== want.green ||
                    out_word.blue !== want.blue || out_word.read_data !== want.read_data ||
                    out_word.last !== want.last)
                begin
                    if (fault_count < 10)
                    begin
                        $display("mismatch: expected kind %0d pixel %0d rgb %h %h %h data %h last %0d",
                                 want.result_kind, want.pixel_index, want.red, want.green,
                                 want.blue, want.read_data, want.last);
                        $display("          actual   kind %0d pixel %0d rgb %h %h %h data %h last %0d",
                                 out_word.result_kind, out_word.pixel_index, out_word.red,
                                 out_word.green, out_word.blue, out_word.read_data,
                                 out_word.last);
                    end
                    fault_count++;
                end
            end
        end
    end

    // Stop if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        foreach (bar_regs[k])
            bar_regs[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 18;
        rx_idle_pct = 70;
        set_interval(8'd0);
        queue_item(lbrc_pkg::MODE_READ, 8'hff, '1);
        queue_item(lbrc_pkg::MODE_TICK, 8'h00, '0);
        queue_item(MODE_UNUSED, 8'hff, '1);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd0, '1);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd6, '1);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd255, '1);
        // full fill, then clear-only, then a count beyond the bar that hits the word cap
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'hff_00_ff_0a_00);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'h56_34_12_00_00);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'h01_02_03_ff_00);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'haa_bb_cc_03_00);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'h11_22_33_0a_01);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'h11_22_33_00_01);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'h11_22_33_0b_01);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd5, 40'h44_55_66_04_ff);
        // short transactions: the pointer carries over and wraps
        queue_item(lbrc_pkg::MODE_WRITE, 8'd2, 40'hff_ff_ff_01_00);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd3, 40'h00_00_ee_dd_cc);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd1, 40'hff_ff_ff_ff_01);
        queue_item(lbrc_pkg::MODE_WRITE, 8'd4, 40'hff_80_40_20_05);
        queue_item(lbrc_pkg::MODE_TICK, 8'hff, '1);
        queue_item(lbrc_pkg::MODE_TICK, 8'h00, '0);
        queue_item(lbrc_pkg::MODE_READ, 8'h00, '0);
        settle();

        set_interval(8'd2);
        repeat (80) queue_random_item();
        settle();

        tx_idle_pct = 70;
        rx_idle_pct = 18;
        set_interval(8'd255);
        repeat (80) queue_random_item();
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_interval(8'd1);
        repeat (80) queue_random_item();
        settle();

        if (fault_count == 0 && due_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: led_bar_register_controller.f
+incdir+rtl
rtl/lbrc_pkg.sv
rtl/lbrc_regs.sv
rtl/lbrc_outq.sv
rtl/lbrc_seq.sv
rtl/led_bar_register_controller.sv
sim/led_bar_register_controller_test.sv
